/* rtl/mt64_pkg.sv */
// ----------------------------------------------------------------------------
// mt64_pkg
// types and constants shared by the 64-bit twister random source
// ----------------------------------------------------------------------------
`default_nettype none

package mt64_pkg;

  localparam int unsigned StateWords = 312;
  localparam int unsigned ShiftOffset = 156;
  localparam int unsigned IdxW = 9;

  localparam logic [63:0] TwistMatrix = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] UpperMask   = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] LowerMask   = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] SeedMult    = 64'd6364136223846793005;
  localparam logic [63:0] SeedReset   = 64'd5489;
  localparam logic [63:0] TempB       = 64'h5555_5555_5555_5555;
  localparam logic [63:0] TempC       = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [63:0] TempD       = 64'hFFF7_EEE0_0000_0000;

  typedef enum logic [1:0] {
    FUNC_RESEED = 2'd0,
    FUNC_RAW    = 2'd1,
    FUNC_RANGE  = 2'd2,
    FUNC_FRAC   = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [63:0] low;
    logic signed [63:0] up;
  } req_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               status;
  } rsp_t;

  // classified command between the front and the back
  typedef struct packed {
    func_e       func;
    logic        empty_iv;
    logic [63:0] low;
    logic [63:0] span;
    logic [63:0] mask;
  } cmd_t;

  function automatic logic [63:0] temper(logic [63:0] v);
    logic [63:0] x;
    x = v;
    x = x ^ ((x >> 29) & TempB);
    x = x ^ ((x << 17) & TempC);
    x = x ^ ((x << 37) & TempD);
    x = x ^ (x >> 43);
    return x;
  endfunction

  function automatic logic [63:0] twist(logic [63:0] cur, logic [63:0] nxt,
                                        logic [63:0] far);
    logic [63:0] x;
    logic [63:0] r;
    x = (cur & UpperMask) | (nxt & LowerMask);
    r = far ^ (x >> 1);
    if (x[0]) begin
      r = r ^ TwistMatrix;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/mt64_front.sv */
// ----------------------------------------------------------------------------
// mt64_front
// accepts requests, checks the interval and builds the covering mask
// ----------------------------------------------------------------------------
`default_nettype none

module mt64_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire mt64_pkg::req_t req_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output mt64_pkg::cmd_t     cmd_o
);
  import mt64_pkg::*;

  localparam int unsigned Depth = 2;

  cmd_t        fifo_q [Depth];
  logic [1:0]  cnt_q, cnt_d;
  logic        wp_q, rp_q;
  logic        do_push, do_pop;
  cmd_t        cmd_new;
  logic [63:0] span;
  logic [63:0] lim;

  always_comb begin
    span = req_i.up - req_i.low;
    lim = span;
    lim = lim | (lim >> 1);
    lim = lim | (lim >> 2);
    lim = lim | (lim >> 4);
    lim = lim | (lim >> 8);
    lim = lim | (lim >> 16);
    lim = lim | (lim >> 32);
    cmd_new.func     = func_e'(req_i.func);
    cmd_new.empty_iv = (req_i.low > req_i.up);
    cmd_new.low      = req_i.low;
    cmd_new.span     = span;
    cmd_new.mask     = lim;
  end

  assign full        = (cnt_q == 2'(Depth));
  assign do_push     = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign do_pop      = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wp_q <= ~wp_q;
      end
      if (do_pop) begin
        rp_q <= ~rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wp_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

/* rtl/mt64_back.sv */
// ----------------------------------------------------------------------------
// mt64_back
// state table sequencer: seeding, regeneration, draws and retries
// ----------------------------------------------------------------------------
`default_nettype none

module mt64_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [63:0]    seed_i,
  input  wire logic           cmd_valid_i,
  output logic                cmd_ready_o,
  input  wire mt64_pkg::cmd_t cmd_i,
  output logic                empty,
  input  wire logic           pop,
  output mt64_pkg::rsp_t      rsp_o
);
  import mt64_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SEED  = 4'd1;
  localparam logic [3:0] S_RG0   = 4'd2;  // neighbor word ready, read far word
  localparam logic [3:0] S_RG1   = 4'd3;  // read far word
  localparam logic [3:0] S_RG2   = 4'd4;  // write twisted word
  localparam logic [3:0] S_DRD   = 4'd5;  // read at index
  localparam logic [3:0] S_DWT   = 4'd6;  // memory data ready
  localparam logic [3:0] S_DTMP  = 4'd7;  // temper registered
  localparam logic [3:0] S_SMUL  = 4'd8;  // seed multiply partial products
  localparam logic [3:0] S_PRE   = 4'd9;  // read word 0 before regenerating
  localparam logic [3:0] S_SSUM  = 4'd10; // sum seed partial products

  localparam logic [IdxW-1:0] LastIdx  = IdxW'(StateWords - 1);
  localparam logic [IdxW-1:0] Used     = IdxW'(StateWords);
  localparam logic [IdxW-1:0] Unseeded = IdxW'(StateWords + 1);
  localparam logic [IdxW-1:0] FarOff   = IdxW'(ShiftOffset);

  logic [63:0]     mem [StateWords];
  logic [63:0]     rdata_q;
  logic [IdxW-1:0] raddr;
  logic            rd_en;
  logic [IdxW-1:0] waddr;
  logic [63:0]     wdata;
  logic            we;

  logic [3:0]      st_q, st_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] i_q, i_d;
  logic [63:0]     mx_q, mx_d;
  logic [63:0]     pa_q, pa_d;
  logic [31:0]     pb_q, pb_d;
  logic [31:0]     pc_q, pc_d;
  logic [63:0]     cur_q, cur_d;
  logic [63:0]     nxt_q, nxt_d;
  logic [63:0]     raw_q, raw_d;
  logic [63:0]     prod_q, prod_d;
  cmd_t            cmd_q, cmd_d;
  logic            busy_q, busy_d;
  logic            ovalid_q, ovalid_d;
  rsp_t            out_q, out_d;
  logic [IdxW-1:0] nx_i;
  logic [IdxW:0]   far_sum;
  logic [IdxW-1:0] far_i;
  logic [63:0]     masked;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  assign nx_i    = (i_q == LastIdx) ? '0 : i_q + IdxW'(1);
  assign far_sum = {1'b0, i_q} + {1'b0, FarOff};
  assign far_i   = (far_sum >= (IdxW+1)'(StateWords)) ?
                   IdxW'(far_sum - (IdxW+1)'(StateWords)) : far_sum[IdxW-1:0];
  assign masked  = raw_q & cmd_q.mask;

  assign empty       = !ovalid_q;
  assign rsp_o       = out_q;
  assign cmd_ready_o = !busy_q && (!ovalid_q || pop);

  always_comb begin
    st_d = st_q; idx_d = idx_q; i_d = i_q; mx_d = mx_q;
    pa_d = pa_q; pb_d = pb_q; pc_d = pc_q;
    cur_d = cur_q; nxt_d = nxt_q; raw_d = raw_q;
    prod_d = prod_q; cmd_d = cmd_q; busy_d = busy_q;
    ovalid_d = ovalid_q; out_d = out_q;
    raddr = '0; rd_en = 1'b0; waddr = '0; wdata = '0; we = 1'b0;
    if (ovalid_q && pop) begin
      ovalid_d = 1'b0;
    end
    unique case (st_q)
      S_IDLE: begin
        if (cmd_valid_i && cmd_ready_o) begin
          cmd_d  = cmd_i;
          busy_d = 1'b1;
          if (cmd_i.func == FUNC_RESEED) begin
            we = 1'b1; waddr = '0; wdata = seed_i;
            mx_d = seed_i ^ (seed_i >> 62); i_d = IdxW'(1); st_d = S_SMUL;
          end else if (idx_q == Unseeded) begin
            we = 1'b1; waddr = '0; wdata = seed_i;
            mx_d = seed_i ^ (seed_i >> 62); i_d = IdxW'(1); st_d = S_SMUL;
          end else begin
            st_d = S_DRD;
          end
        end
      end
      S_SMUL: begin
        pa_d = mx_q[31:0] * SeedMult[31:0];
        pb_d = mx_q[63:32] * SeedMult[31:0];
        pc_d = mx_q[31:0] * SeedMult[63:32];
        st_d = S_SSUM;
      end
      S_SSUM: begin
        prod_d = pa_q + {pb_q + pc_q, 32'd0};
        st_d = S_SEED;
      end
      S_SEED: begin
        we = 1'b1; waddr = i_q;
        wdata = prod_q + 64'(i_q);
        mx_d = wdata ^ (wdata >> 62);
        if (i_q == LastIdx) begin
          idx_d = Used;
          if (cmd_q.func == FUNC_RESEED) begin
            ovalid_d = 1'b1; out_d = '0; busy_d = 1'b0; st_d = S_IDLE;
          end else begin
            st_d = S_DRD;
          end
        end else begin
          i_d = i_q + IdxW'(1); st_d = S_SMUL;
        end
      end
      S_DRD: begin
        if (idx_q == Used) begin
          rd_en = 1'b1; raddr = '0; i_d = '0; st_d = S_PRE;
        end else begin
          rd_en = 1'b1; raddr = idx_q; st_d = S_DWT;
        end
      end
      S_PRE: begin
        cur_d = rdata_q;
        rd_en = 1'b1; raddr = nx_i; st_d = S_RG0;
      end
      S_RG0: begin
        nxt_d = rdata_q;
        rd_en = 1'b1; raddr = far_i; st_d = S_RG1;
      end
      S_RG1: begin
        st_d = S_RG2;
      end
      S_RG2: begin
        we = 1'b1; waddr = i_q;
        wdata = twist(cur_q, nxt_q, rdata_q);
        cur_d = nxt_q;
        if (i_q == LastIdx) begin
          idx_d = '0; st_d = S_DRD;
        end else begin
          i_d = nx_i;
          // prefetch the next neighbor; word 0 is read back already regenerated
          rd_en = 1'b1; raddr = (nx_i == LastIdx) ? '0 : nx_i + IdxW'(1);
          st_d = S_RG0;
        end
      end
      S_DWT: begin
        idx_d = idx_q + IdxW'(1);
        raw_d = temper(rdata_q);
        st_d = S_DTMP;
      end
      S_DTMP: begin
        unique case (cmd_q.func)
          FUNC_RAW: begin
            out_d.value = raw_q; out_d.status = 1'b0;
            ovalid_d = 1'b1; busy_d = 1'b0; st_d = S_IDLE;
          end
          FUNC_FRAC: begin
            out_d.value = raw_q >> 12; out_d.status = 1'b0;
            ovalid_d = 1'b1; busy_d = 1'b0; st_d = S_IDLE;
          end
          FUNC_RANGE: begin
            if (cmd_q.empty_iv) begin
              out_d.value = '0; out_d.status = 1'b1;
              ovalid_d = 1'b1; busy_d = 1'b0; st_d = S_IDLE;
            end else if (masked > cmd_q.span) begin
              st_d = S_DRD;
            end else begin
              out_d.value = masked + cmd_q.low; out_d.status = 1'b0;
              ovalid_d = 1'b1; busy_d = 1'b0; st_d = S_IDLE;
            end
          end
          default: begin
            busy_d = 1'b0; st_d = S_IDLE;
          end
        endcase
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      idx_q    <= Unseeded;
      i_q      <= '0;
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      idx_q    <= idx_d;
      i_q      <= i_d;
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q   <= mx_d;
    pa_q   <= pa_d;
    pb_q   <= pb_d;
    pc_q   <= pc_d;
    cur_q  <= cur_d;
    nxt_q  <= nxt_d;
    raw_q  <= raw_d;
    prod_q <= prod_d;
    cmd_q  <= cmd_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

/* rtl/mt64_random_with_range.sv */
// ----------------------------------------------------------------------------
// mt64_random_with_range
// 64-bit twister random source with raw, ranged and fraction draws
// ----------------------------------------------------------------------------
// requests enter through push/full; results leave through empty/pop,
// one result per request in request order. the seed register is written
// through seed_valid/seed_ready; the user must write it only while the
// block is idle, the block itself does not enforce it. a front stage checks
// the interval and builds the retry mask; a two-entry queue feeds the back
// sequencer that owns the 312-word table. a draw from a live table passes
// the read, data-ready and temper states of the sequencer, and a retry
// draw passes them again. once every 312 draws the table is regenerated
// word by word (one read and one write port). seeding writes each word
// through partial products, sum and add, on a reseed request or on the
// first draw after reset. reset empties the queues and marks the table
// unseeded; seed goes to 5489. a stalled result holds the back part; the
// front keeps taking requests until its queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module mt64_random_with_range (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire mt64_pkg::req_t req_i,
  output logic                empty,
  input  wire logic           pop,
  output mt64_pkg::rsp_t      rsp_o,
  input  wire logic           seed_valid,
  output logic                seed_ready,
  input  wire logic [63:0]    seed_i
);
  import mt64_pkg::*;

  logic [63:0] seed_q;
  logic        cmd_valid;
  logic        cmd_ready;
  cmd_t        cmd;

  assign seed_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
    end else if (seed_valid) begin
      seed_q <= seed_i;
    end
  end

  mt64_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  mt64_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (seed_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

/* rtl/mt64_checker.sv */
// ----------------------------------------------------------------------------
// mt64_checker
// port-level checks of the random source
// ----------------------------------------------------------------------------
`default_nettype none

module mt64_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           full,
  input wire logic           empty,
  input wire logic           pop,
  input wire mt64_pkg::rsp_t rsp_o
);
  import mt64_pkg::*;

  // a result beat not taken stays the same
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(rsp_o)))
    else $error("result changed while waiting");

  // an empty interval always yields a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.status) |-> (rsp_o.value == '0))
    else $error("error beat carries a value");

  // after reset nothing is waiting
  a_rst: assert property (@(posedge clk_i)
    !rst_ni |=> empty)
    else $error("result present after reset");

  // the input queue is not full right after reset
  a_full_rst: assert property (@(posedge clk_i)
    !rst_ni |=> !full)
    else $error("full after reset");

endmodule

bind mt64_random_with_range mt64_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .rsp_o  (rsp_o)
);

`default_nettype wire
